/* design/merging_range_table_top_assert.svh */
// Assertion macros used by the range table checker.
`ifndef MERGING_RANGE_TABLE_TOP_ASSERT_SVH
`define MERGING_RANGE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define MRT_ASSERT_SAME(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("range table assertion failed");

// Next-cycle implication, clocked on clock, off during reset.
`define MRT_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("range table assertion failed");

`endif

/* design/mrt_pkg.sv */
// Shared types and constants of the merging range table.
package mrt_pkg;

   localparam int START_W         = 62;
   localparam int SIZE_W          = 63;
   localparam int OP_W            = 2;
   localparam int IDX_W           = 6;
   localparam int STATUS_W        = 2;
   localparam int MAX_RANGES_DEF  = 64;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [SIZE_W-1:0]  size;
   } entry_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 2'd0,
      OP_LOOKUP  = 2'd1,
      OP_PRESENT = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_UP,
      CELL_DOWN
   } cell_op_type;

   typedef enum logic [2:0] {
      SK_HOLD,
      SK_PUSH,
      SK_POP,
      SK_SET,
      SK_POPSET
   } stack_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MERGE_PREV,
      S_MERGE_NEXT,
      S_REWIND
   } state_type;

endpackage

/* design/merging_range_table_top.sv */
// Merging range table: sorted (start, size) ranges kept in a pair of cell stacks.
//
//   channel   ports                                  handshake
//   request   req_opcode/query_offset/size/index     start, busy
//   response  rsp_status/found_start/found_size      rsp_valid, one cycle
//
// The table sits in two stacks with a cursor between them: the entries before
// the cursor in the left stack, the rest in the right stack, current on top.
// An item steps the cursor over entries (up to the range count), an add may then
// merge with its previous and next neighbours, and the cursor is rewound entry by
// entry, bounded by the one-entry-per-cycle stack shift.
// rsp_valid pulses once per item; busy stays high until the rewind ends.
// Reset is synchronous and leaves an empty table.
module merging_range_table_top #(
   parameter int MAX_RANGES = mrt_pkg::MAX_RANGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mrt_pkg::OP_W-1:0]      req_opcode,
   input  logic [mrt_pkg::START_W-1:0]   req_query_offset,
   input  logic [mrt_pkg::START_W-1:0]   req_query_size,
   input  logic [mrt_pkg::IDX_W-1:0]     req_entry_index,
   output logic                          rsp_valid,
   output logic [mrt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mrt_pkg::START_W-1:0]   rsp_found_start,
   output logic [mrt_pkg::SIZE_W-1:0]    rsp_found_size
);
   import mrt_pkg::*;

   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int IW = (CW > IDX_W) ? CW : IDX_W;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [START_W-1:0]   off_ff, off_in;
   logic [START_W-1:0]   len_ff, len_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [CW-1:0]        lcnt_ff, lcnt_in;
   logic [CW-1:0]        rcnt_ff, rcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [START_W-1:0]   fstart_ff, fstart_in;
   logic [SIZE_W-1:0]    fsize_ff, fsize_in;

   stack_op_type         l_op, r_op;
   entry_type            l_in, r_in;
   entry_type            prev, cur, nxt, l_second;

   logic [SIZE_W-1:0]    cur_s, cur_end, prev_end, off_x, q_end, size_a;
   logic                 hit_a, hit_b, hit_c, overlap, full, l_has, r_has, r_has2;
   entry_type            new_entry;

   mrt_stack #(.DEPTH(MAX_RANGES)) u_left (
      .clock      (clock),
      .op         (l_op),
      .top_in     (l_in),
      .top_out    (prev),
      .second_out (l_second)
   );

   mrt_stack #(.DEPTH(MAX_RANGES)) u_right (
      .clock      (clock),
      .op         (r_op),
      .top_in     (r_in),
      .top_out    (cur),
      .second_out (nxt)
   );

   assign cur_s    = {1'b0, cur.start};
   assign cur_end  = cur_s + cur.size;
   assign prev_end = {1'b0, prev.start} + prev.size;
   assign off_x    = {1'b0, off_ff};
   assign q_end    = off_x + {1'b0, len_ff};
   assign hit_a    = (off_x >= cur_s) && (off_x <= cur_end);
   assign hit_b    = (q_end >= cur_s) && (q_end <= cur_end);
   assign hit_c    = (off_x < cur_s) && (q_end > cur_end);
   assign overlap  = ((off_x >= cur_s) && (off_x < cur_end)) ||
                     ((cur_s >= off_x) && (cur_s < q_end));
   assign size_a   = (q_end > cur_end) ? (q_end - cur_s) : cur.size;
   assign full     = (lcnt_ff + rcnt_ff) == CW'(MAX_RANGES);
   assign l_has    = lcnt_ff != '0;
   assign r_has    = rcnt_ff != '0;
   assign r_has2   = rcnt_ff > CW'(1);
   assign new_entry = '{start: off_ff, size: {1'b0, len_ff}};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lcnt_ff      <= '0;
         rcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcnt_ff      <= lcnt_in;
         rcnt_ff      <= rcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      off_ff    <= off_in;
      len_ff    <= len_in;
      idx_ff    <= idx_in;
      pend_ff   <= pend_in;
      status_ff <= status_in;
      fstart_ff <= fstart_in;
      fsize_ff  <= fsize_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      off_in       = off_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      lcnt_in      = lcnt_ff;
      rcnt_in      = rcnt_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      fstart_in    = fstart_ff;
      fsize_in     = fsize_ff;
      l_op         = SK_HOLD;
      r_op         = SK_HOLD;
      l_in         = cur;
      r_in         = cur;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = op_type'(req_opcode);
               off_in = req_query_offset;
               len_in = req_query_size;
               idx_in = req_entry_index;
               if ((op_type'(req_opcode) == OP_READ) &&
                   (IW'(req_entry_index) >= IW'(rcnt_ff))) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STAT_MISS;
                  fstart_in    = '0;
                  fsize_in     = '0;
                  state_in     = S_REWIND;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            fstart_in = '0;
            fsize_in  = '0;
            status_in = STAT_OK;
            unique case (op_ff)
               OP_ADD: begin
                  if (!r_has || (!hit_a && !hit_b && !hit_c && (cur_s >= off_x))) begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        r_op    = SK_PUSH;
                        r_in    = new_entry;
                        rcnt_in = rcnt_ff + CW'(1);
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = S_REWIND;
                  end else if (hit_a) begin
                     r_op     = SK_SET;
                     r_in     = '{start: cur.start, size: size_a};
                     state_in = S_MERGE_NEXT;
                  end else if (hit_b) begin
                     r_op     = SK_SET;
                     r_in     = '{start: off_ff, size: cur_end - off_x};
                     pend_in  = 1'b0;
                     state_in = S_MERGE_PREV;
                  end else if (hit_c) begin
                     r_op     = SK_SET;
                     r_in     = new_entry;
                     pend_in  = 1'b1;
                     state_in = S_MERGE_PREV;
                  end else begin
                     l_op    = SK_PUSH;
                     r_op    = SK_POP;
                     lcnt_in = lcnt_ff + CW'(1);
                     rcnt_in = rcnt_ff - CW'(1);
                  end
               end
               OP_LOOKUP: begin
                  if (!r_has) begin
                     status_in    = STAT_MISS;
                     rsp_valid_in = 1'b1;
                     state_in     = S_REWIND;
                  end else if (hit_a) begin
                     fstart_in    = cur.start;
                     fsize_in     = cur.size;
                     rsp_valid_in = 1'b1;
                     state_in     = S_REWIND;
                  end else begin
                     l_op    = SK_PUSH;
                     r_op    = SK_POP;
                     lcnt_in = lcnt_ff + CW'(1);
                     rcnt_in = rcnt_ff - CW'(1);
                  end
               end
               OP_PRESENT: begin
                  if (!r_has || overlap) begin
                     status_in    = r_has ? STAT_OK : STAT_MISS;
                     rsp_valid_in = 1'b1;
                     state_in     = S_REWIND;
                  end else begin
                     l_op    = SK_PUSH;
                     r_op    = SK_POP;
                     lcnt_in = lcnt_ff + CW'(1);
                     rcnt_in = rcnt_ff - CW'(1);
                  end
               end
               OP_READ: begin
                  if (IW'(lcnt_ff) == IW'(idx_ff)) begin
                     fstart_in    = cur.start;
                     fsize_in     = cur.size;
                     rsp_valid_in = 1'b1;
                     state_in     = S_REWIND;
                  end else begin
                     l_op    = SK_PUSH;
                     r_op    = SK_POP;
                     lcnt_in = lcnt_ff + CW'(1);
                     rcnt_in = rcnt_ff - CW'(1);
                  end
               end
               default: state_in = S_REWIND;
            endcase
         end

         S_MERGE_PREV: begin
            if (l_has && (prev_end == cur_s)) begin
               l_op    = SK_POP;
               r_op    = SK_SET;
               r_in    = '{start: prev.start, size: prev.size + cur.size};
               lcnt_in = lcnt_ff - CW'(1);
            end
            if (pend_ff) begin
               state_in = S_MERGE_NEXT;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_REWIND;
            end
         end

         S_MERGE_NEXT: begin
            if (r_has2 && (cur_end == {1'b0, nxt.start})) begin
               r_op    = SK_POPSET;
               r_in    = '{start: cur.start, size: cur.size + nxt.size};
               rcnt_in = rcnt_ff - CW'(1);
            end
            rsp_valid_in = 1'b1;
            state_in     = S_REWIND;
         end

         S_REWIND: begin
            if (l_has) begin
               r_op    = SK_PUSH;
               r_in    = prev;
               l_op    = SK_POP;
               lcnt_in = lcnt_ff - CW'(1);
               rcnt_in = rcnt_ff + CW'(1);
            end else begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_start = fstart_ff;
   assign rsp_found_size  = fsize_ff;

endmodule

/* design/mrt_cell.sv */
// One storage cell of a range stack: holds one entry, loads from a neighbor.
module mrt_cell (
   input  logic                 clock,
   input  mrt_pkg::cell_op_type op,
   input  mrt_pkg::entry_type   up_in,
   input  mrt_pkg::entry_type   down_in,
   output mrt_pkg::entry_type   data_out
);
   import mrt_pkg::*;

   entry_type data_ff;
   entry_type data_in;

   always_comb begin
      case (op)
         CELL_UP:   data_in = up_in;
         CELL_DOWN: data_in = down_in;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

/* design/mrt_stack.sv */
// Stack of range entries built as a chain of cells; top and second are visible.
module mrt_stack #(
   parameter int DEPTH = mrt_pkg::MAX_RANGES_DEF
) (
   input  logic                  clock,
   input  mrt_pkg::stack_op_type op,
   input  mrt_pkg::entry_type    top_in,
   output mrt_pkg::entry_type    top_out,
   output mrt_pkg::entry_type    second_out
);
   import mrt_pkg::*;

   entry_type   cell_q [DEPTH];
   cell_op_type head_op;
   cell_op_type body_op;

   always_comb begin
      case (op)
         SK_PUSH: begin
            head_op = CELL_UP;
            body_op = CELL_UP;
         end
         SK_POP: begin
            head_op = CELL_DOWN;
            body_op = CELL_DOWN;
         end
         SK_SET: begin
            head_op = CELL_UP;
            body_op = CELL_HOLD;
         end
         SK_POPSET: begin
            head_op = CELL_UP;
            body_op = CELL_DOWN;
         end
         default: begin
            head_op = CELL_HOLD;
            body_op = CELL_HOLD;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type   up_d;
      entry_type   down_d;
      cell_op_type cop;
      if (i == 0) begin : g_head
         assign up_d = top_in;
         assign cop  = head_op;
      end else begin : g_body
         assign up_d = cell_q[i-1];
         assign cop  = body_op;
      end
      if (i == DEPTH-1) begin : g_last
         assign down_d = '0;
      end else begin : g_mid
         assign down_d = cell_q[i+1];
      end
      mrt_cell u_cell (
         .clock    (clock),
         .op       (cop),
         .up_in    (up_d),
         .down_in  (down_d),
         .data_out (cell_q[i])
      );
   end

   assign top_out    = cell_q[0];
   assign second_out = cell_q[1];

endmodule

/* design/mrt_checker.sv */
// Port-level checks of the merging range table and their bind.
`include "merging_range_table_top_assert.svh"

module mrt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [mrt_pkg::STATUS_W-1:0]  rsp_status,
   input logic [mrt_pkg::START_W-1:0]   rsp_found_start,
   input logic [mrt_pkg::SIZE_W-1:0]    rsp_found_size
);
   import mrt_pkg::*;

   `MRT_ASSERT_SAME(a_rsp_in_busy, rsp_valid, busy)
   `MRT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
   `MRT_ASSERT_NEXT(a_rsp_pulse, rsp_valid, !rsp_valid)
   `MRT_ASSERT_SAME(a_miss_zero, rsp_valid && (rsp_status != STAT_OK),
      (rsp_found_start == '0) && (rsp_found_size == '0))

endmodule

bind merging_range_table_top mrt_checker u_mrt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_found_start (rsp_found_start),
   .rsp_found_size  (rsp_found_size)
);
